/* sv/pid_aw_pkg.sv */
// ----------------------------------------------------------------------------
// pid_aw_pkg
// shared constants, control word format and microcode for the pid controller
// ----------------------------------------------------------------------------
package pid_aw_pkg;

	localparam int INTEGRAL_WIDTH = 48;

	localparam int SAMPLE_W = 16;
	localparam int DT_W     = 16;
	localparam int ERR_W    = SAMPLE_W + 1;
	localparam int GAIN_W   = 32;
	localparam int MUL_W    = GAIN_W + 1;
	localparam int PROD_W   = 64;
	localparam int WIDE_W   = PROD_W + 1;
	localparam int DIVD_W   = ERR_W + DT_W;
	localparam int DRIVE_W  = 16;
	localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

	localparam logic signed [WIDE_W-1:0] INTEG_MAX =
		(WIDE_W'(1) <<< (INTEGRAL_WIDTH - 1)) - WIDE_W'(1);
	localparam logic signed [WIDE_W-1:0] INTEG_MIN = -INTEG_MAX - WIDE_W'(1);
	localparam logic signed [WIDE_W-1:0] OP_MAX = WIDE_W'(64'sh7fff_ffff);
	localparam logic signed [WIDE_W-1:0] OP_MIN = -OP_MAX - WIDE_W'(1);
	localparam logic signed [PROD_W-1:0] ONE_Q28 = PROD_W'(64'sh1000_0000);
	localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 16'sh7fff;
	localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -16'sh7fff;

	typedef enum logic [1:0] {
		CFG_TARGET = 2'd0,
		CFG_PROP   = 2'd1,
		CFG_INTEG  = 2'd2,
		CFG_DERIV  = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_ERR_DT,
		MUL_KP,
		MUL_KI,
		MUL_KD
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_INTEG,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     ld_err;
		logic     div_start;
		logic     ld_iop;
		logic     ld_deriv;
		logic     wait_div;
		logic     emit;
		logic     last;
	} ctrl_t;

	localparam int PROG_LEN = 11;
	localparam int PC_W     = $clog2(PROG_LEN);

	localparam ctrl_t CTRL_NOP = '{MUL_NONE, ACC_NONE, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0};

	function automatic ctrl_t ctrl_rom(input logic [PC_W-1:0] pc);
		ctrl_t c;
		c = CTRL_NOP;
		case (pc)
			4'd0: c.ld_err = 1'b1;
			4'd1: begin
				c.div_start = 1'b1;
				c.mul_sel   = MUL_ERR_DT;
			end
			4'd2: begin
				c.acc_op  = ACC_INTEG;
				c.mul_sel = MUL_KP;
			end
			4'd3: begin
				c.ld_iop = 1'b1;
				c.acc_op = ACC_LOAD;
			end
			4'd4: c.mul_sel = MUL_KI;
			4'd5: c.acc_op = ACC_ADD;
			4'd6: c.wait_div = 1'b1;
			4'd7: c.ld_deriv = 1'b1;
			4'd8: c.mul_sel = MUL_KD;
			4'd9: c.acc_op = ACC_ADD;
			4'd10: begin
				c.emit = 1'b1;
				c.last = 1'b1;
			end
			default: c = CTRL_NOP;
		endcase
		return c;
	endfunction

endpackage

/* sv/pid_controller_antiwindup.sv */
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// fixed-point pid controller with conditional-integration anti-windup
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one item per control period: tdata[15:0] measured sample
//   (q4.12), tdata[31:16] time step (q0.16). m_axis returns one item for
//   each: tdata[15:0] drive value (q1.15), tuser[0] output clamped,
//   tuser[1] integral held. setpoint and the three gains are written on the
//   cfg channel (index 0..3) while the block is idle.
// timing:
//   a microcoded sequencer steps through an 11-word program; one shared
//   33x33 multiplier forms all products and a radix-2 divider (33 steps)
//   forms the derivative. the divider sets the pace; a new item is only
//   accepted once the last one has left the program.
// reset and stall:
//   arst_n clears gains, setpoint, last error and integral; the next output
//   counts as inside. a result waits in the output register while m_axis is
//   stalled; the next item is still accepted and stops at its final step
//   until the register frees up.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // measured_sample, time_step
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // drive_value
	output logic [1:0]  m_axis_tuser,  // output_clamped, integral_held
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int IW = pid_aw_pkg::INTEGRAL_WIDTH;
	localparam int PCW = pid_aw_pkg::PC_W;
	localparam int WW = pid_aw_pkg::WIDE_W;
	localparam int PW = pid_aw_pkg::PROD_W;
	localparam int MW = pid_aw_pkg::MUL_W;
	localparam int EW = pid_aw_pkg::ERR_W;
	localparam int DW = pid_aw_pkg::DT_W;
	localparam int QW = pid_aw_pkg::DIVD_W;
	localparam int CW = pid_aw_pkg::DIV_CNT_W;

	// configuration
	logic signed [15:0] target_q;
	logic signed [31:0] kp_q;
	logic signed [31:0] ki_q;
	logic signed [31:0] kd_q;

	// sequencer
	logic               busy_q;
	logic [PCW-1:0]     pc_q;
	pid_aw_pkg::ctrl_t  ctrl;
	logic               hold;
	logic               step_go;
	logic               in_fire;
	logic               out_free;
	logic               emit_fire;

	// datapath
	logic signed [15:0]   sample_q;
	logic [DW-1:0]        dt_q;
	logic signed [EW-1:0] err_q;
	logic signed [EW-1:0] last_err_q;
	logic signed [IW-1:0] integ_q;
	logic                 inside_q;
	logic signed [31:0]   iop_q;
	logic signed [31:0]   deriv_q;
	logic signed [PW-1:0] prod_q;
	logic signed [PW-1:0] u_q;

	logic signed [MW-1:0]   mul_a;
	logic signed [MW-1:0]   mul_b;
	logic signed [2*MW-1:0] mul_full;
	logic signed [WW-1:0]   isum;
	logic signed [WW-1:0]   iext;
	logic signed [WW-1:0]   usum;
	logic signed [EW:0]     diff;
	logic [EW:0]            diff_abs;

	// divider
	logic [DW:0]     div_rem_q;
	logic [QW-1:0]   div_quo_q;
	logic [CW-1:0]   div_cnt_q;
	logic            div_neg_q;
	logic            div_busy;
	logic [DW:0]     rem_sh;
	logic            rem_ge;

	// output stage
	logic                 u_gt;
	logic                 u_lt;
	logic signed [29:0]   rnd;
	logic signed [16:0]   rnd_shr;
	logic signed [15:0]   drive;
	logic                 out_valid_q;
	logic [15:0]          out_data_q;
	logic [1:0]           out_user_q;

	assign cfg_ready = !busy_q;
	assign s_axis_tready = !busy_q;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			kp_q <= '0;
			ki_q <= '0;
			kd_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (pid_aw_pkg::cfg_index_t'(cfg_index))
				pid_aw_pkg::CFG_TARGET: target_q <= cfg_data[15:0];
				pid_aw_pkg::CFG_PROP:   kp_q <= cfg_data;
				pid_aw_pkg::CFG_INTEG:  ki_q <= cfg_data;
				pid_aw_pkg::CFG_DERIV:  kd_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// microcode sequencing
	assign ctrl = pid_aw_pkg::ctrl_rom(pc_q);
	assign out_free = !out_valid_q || m_axis_tready;
	assign div_busy = (div_cnt_q != '0);
	assign hold = (ctrl.wait_div && div_busy) || (ctrl.emit && !out_free);
	assign step_go = busy_q && !hold;
	assign emit_fire = step_go && ctrl.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q <= '0;
		end else if (in_fire) begin
			busy_q <= 1'b1;
			pc_q <= '0;
		end else if (step_go) begin
			if (ctrl.last) begin
				busy_q <= 1'b0;
			end else begin
				pc_q <= pc_q + PCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_q <= s_axis_tdata[15:0];
			dt_q <= s_axis_tdata[31:16];
		end
	end

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.mul_sel)
			pid_aw_pkg::MUL_ERR_DT: begin
				mul_a = MW'(err_q);
				mul_b = MW'({1'b0, dt_q});
			end
			pid_aw_pkg::MUL_KP: begin
				mul_a = MW'(kp_q);
				mul_b = MW'(err_q);
			end
			pid_aw_pkg::MUL_KI: begin
				mul_a = MW'(ki_q);
				mul_b = MW'(iop_q);
			end
			pid_aw_pkg::MUL_KD: begin
				mul_a = MW'(kd_q);
				mul_b = MW'(deriv_q);
			end
			default: ;
		endcase
	end

	assign mul_full = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (busy_q && ctrl.mul_sel != pid_aw_pkg::MUL_NONE) begin
			prod_q <= mul_full[PW-1:0];
		end
	end

	// error, integral, integral operand and output accumulator
	assign isum = WW'(integ_q) + WW'(prod_q);
	assign iext = WW'(integ_q) >>> 16;
	assign usum = WW'(u_q) + WW'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
			integ_q <= '0;
			inside_q <= 1'b1;
		end else begin
			if (busy_q && ctrl.acc_op == pid_aw_pkg::ACC_INTEG && inside_q) begin
				if (isum > pid_aw_pkg::INTEG_MAX) begin
					integ_q <= pid_aw_pkg::INTEG_MAX[IW-1:0];
				end else if (isum < pid_aw_pkg::INTEG_MIN) begin
					integ_q <= pid_aw_pkg::INTEG_MIN[IW-1:0];
				end else begin
					integ_q <= isum[IW-1:0];
				end
			end
			if (emit_fire) begin
				last_err_q <= err_q;
				inside_q <= !u_gt && !u_lt && (u_q != pid_aw_pkg::ONE_Q28) &&
					(u_q != -pid_aw_pkg::ONE_Q28);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && ctrl.ld_err) begin
			err_q <= EW'(target_q) - EW'(sample_q);
		end
		if (busy_q && ctrl.ld_iop) begin
			if (iext > pid_aw_pkg::OP_MAX) begin
				iop_q <= pid_aw_pkg::OP_MAX[31:0];
			end else if (iext < pid_aw_pkg::OP_MIN) begin
				iop_q <= pid_aw_pkg::OP_MIN[31:0];
			end else begin
				iop_q <= iext[31:0];
			end
		end
		if (busy_q && ctrl.acc_op == pid_aw_pkg::ACC_LOAD) begin
			u_q <= prod_q;
		end else if (busy_q && ctrl.acc_op == pid_aw_pkg::ACC_ADD) begin
			if (usum[WW-1] != usum[WW-2]) begin
				u_q <= {usum[WW-1], {(PW-1){!usum[WW-1]}}};
			end else begin
				u_q <= usum[PW-1:0];
			end
		end
	end

	// radix-2 restoring divider for the derivative
	assign diff = (EW+1)'(err_q) - (EW+1)'(last_err_q);
	assign diff_abs = diff[EW] ? (EW+1)'(-diff) : (EW+1)'(diff);
	assign rem_sh = {div_rem_q[DW-1:0], div_quo_q[QW-1]};
	assign rem_ge = (rem_sh >= {1'b0, dt_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (busy_q && ctrl.div_start) begin
			div_cnt_q <= CW'(QW);
		end else if (div_busy) begin
			div_cnt_q <= div_cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && ctrl.div_start) begin
			div_rem_q <= '0;
			div_quo_q <= {diff_abs[EW-1:0], {DW{1'b0}}};
			div_neg_q <= diff[EW];
		end else if (div_busy) begin
			div_rem_q <= rem_ge ? (rem_sh - {1'b0, dt_q}) : rem_sh;
			div_quo_q <= {div_quo_q[QW-2:0], rem_ge};
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && ctrl.ld_deriv) begin
			if (dt_q == '0) begin
				deriv_q <= '0;
			end else if (div_neg_q) begin
				if (div_quo_q > QW'(33'h0_8000_0000)) begin
					deriv_q <= 32'sh8000_0000;
				end else begin
					deriv_q <= 32'(-div_quo_q);
				end
			end else begin
				if (div_quo_q > QW'(33'h0_7fff_ffff)) begin
					deriv_q <= 32'sh7fff_ffff;
				end else begin
					deriv_q <= div_quo_q[31:0];
				end
			end
		end
	end

	// output clamp and rounding
	assign u_gt = (u_q > pid_aw_pkg::ONE_Q28);
	assign u_lt = (u_q < -pid_aw_pkg::ONE_Q28);
	assign rnd = u_q[29:0] + 30'sd4096;
	assign rnd_shr = rnd[29:13];

	always_comb begin
		if (u_gt) begin
			drive = pid_aw_pkg::DRIVE_MAX;
		end else if (u_lt) begin
			drive = pid_aw_pkg::DRIVE_MIN;
		end else if (rnd_shr > 17'(pid_aw_pkg::DRIVE_MAX)) begin
			drive = pid_aw_pkg::DRIVE_MAX;
		end else if (rnd_shr < 17'(pid_aw_pkg::DRIVE_MIN)) begin
			drive = pid_aw_pkg::DRIVE_MIN;
		end else begin
			drive = rnd_shr[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_data_q <= drive;
			out_user_q <= {!inside_q, u_gt || u_lt};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_user_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> busy_q)
		else $error("divider running outside an item");

	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pc_q < PCW'(pid_aw_pkg::PROG_LEN)))
		else $error("step counter beyond program");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |->
		(m_axis_tdata == 16'h7fff || m_axis_tdata == 16'h8001))
		else $error("clamped item without full-scale drive");

	assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && ctrl.ld_deriv) |-> !div_busy)
		else $error("derivative taken before divider finished");
`endif

endmodule
